FILE: rtl/sxt_pkg.sv
// Shared definitions for the S-expression tokenizer.
// Holds token kinds, register indexes, byte codes, byte classes and the
// queue control struct. Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package sxt_pkg;

  // Token kinds as they appear on the token channel.
  localparam logic [2:0] KIND_LPAREN  = 3'd0;
  localparam logic [2:0] KIND_RPAREN  = 3'd1;
  localparam logic [2:0] KIND_QUOTE   = 3'd2;
  localparam logic [2:0] KIND_INTEGER = 3'd3;
  localparam logic [2:0] KIND_DECIMAL = 3'd4;
  localparam logic [2:0] KIND_SYMBOL  = 3'd5;
  localparam logic [2:0] KIND_ERROR   = 3'd6;

  // Configuration register indexes and port widths.
  localparam int unsigned CFG_INDEX_BITS = 8;
  localparam int unsigned CFG_DATA_BITS  = 16;
  localparam logic [CFG_INDEX_BITS-1:0] REG_START_LINE   = 8'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_START_COLUMN = 8'd1;
  localparam logic [CFG_DATA_BITS-1:0]  START_LINE_RESET   = 16'd1;
  localparam logic [CFG_DATA_BITS-1:0]  START_COLUMN_RESET = 16'd0;

  // Token queue geometry.
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QUEUE_PTR_BITS = 2;
  localparam int unsigned QUEUE_COUNT_BITS = 3;

  // Byte codes the lexer tests for.
  localparam logic [7:0] CHAR_BANG    = 8'h21;
  localparam logic [7:0] CHAR_TILDE   = 8'h7E;
  localparam logic [7:0] CHAR_SEMI    = 8'h3B;
  localparam logic [7:0] CHAR_DOT     = 8'h2E;
  localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
  localparam logic [7:0] CHAR_SPACE   = 8'h20;
  localparam logic [7:0] CHAR_TAB     = 8'h09;
  localparam logic [7:0] CHAR_CR      = 8'h0D;
  localparam logic [7:0] CHAR_DQUOTE  = 8'h22;
  localparam logic [7:0] CHAR_LPAREN  = 8'h28;
  localparam logic [7:0] CHAR_RPAREN  = 8'h29;
  localparam logic [7:0] CHAR_QUOTE   = 8'h27;
  localparam logic [7:0] CHAR_PLUS    = 8'h2B;
  localparam logic [7:0] CHAR_MINUS   = 8'h2D;
  localparam logic [7:0] CHAR_ZERO    = 8'h30;
  localparam logic [7:0] CHAR_NINE    = 8'h39;

  // Which slots of the token queue are written in a cycle.
  typedef struct packed {
    logic first;
    logic second;
  } push_t;

  function automatic logic is_space(input logic [7:0] b);
    return (b == CHAR_SPACE) || ((b >= CHAR_TAB) && (b <= CHAR_CR));
  endfunction

  function automatic logic is_digit(input logic [7:0] b);
    return (b >= CHAR_ZERO) && (b <= CHAR_NINE);
  endfunction

  function automatic logic is_sign(input logic [7:0] b);
    return (b == CHAR_PLUS) || (b == CHAR_MINUS);
  endfunction

  function automatic logic is_symbolic(input logic [7:0] b);
    return (b >= CHAR_BANG) && (b <= CHAR_TILDE) && (b != CHAR_DQUOTE) &&
           (b != CHAR_LPAREN) && (b != CHAR_RPAREN) && (b != CHAR_QUOTE);
  endfunction

endpackage

`default_nettype wire

FILE: rtl/sxt_if.sv
// Channel interfaces of the S-expression tokenizer: text bytes in,
// register writes in, tokens out. Depends on sxt_pkg.
`timescale 1ns / 1ps
`default_nettype none

// Text byte channel.
interface sxt_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       end_of_text;

  modport source (output valid, output text_byte, output end_of_text, input ready);
  modport sink   (input valid, input text_byte, input end_of_text, output ready);
endinterface

// Register write channel.
interface sxt_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [sxt_pkg::CFG_INDEX_BITS-1:0] reg_index;
  logic [sxt_pkg::CFG_DATA_BITS-1:0]  reg_data;

  modport source (output valid, output reg_index, output reg_data, input ready);
  modport sink   (input valid, input reg_index, input reg_data, output ready);
endinterface

// Token channel.
interface sxt_token_if #(
  parameter int unsigned LINE_BITS   = 16,
  parameter int unsigned COLUMN_BITS = 16,
  parameter int unsigned OFFSET_BITS = 24
);
  logic                   valid;
  logic                   ready;
  logic [2:0]             token_kind;
  logic [LINE_BITS-1:0]   token_line;
  logic [COLUMN_BITS-1:0] token_column;
  logic [OFFSET_BITS-1:0] token_offset;
  logic [OFFSET_BITS-1:0] token_length;
  logic                   run_last;

  modport source (
    output valid, output token_kind, output token_line, output token_column,
    output token_offset, output token_length, output run_last, input ready
  );
  modport sink (
    input valid, input token_kind, input token_line, input token_column,
    input token_offset, input token_length, input run_last, output ready
  );
endinterface

`default_nettype wire

FILE: rtl/sxt_token_fifo.sv
// Four-entry token queue that takes up to two tokens a cycle and gives one.
// Depends on sxt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sxt_token_fifo #(
  parameter int unsigned WIDTH = 84
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire sxt_pkg::push_t    push,
  input  wire logic [WIDTH-1:0]  din0,
  input  wire logic [WIDTH-1:0]  din1,
  output logic                   room,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [WIDTH-1:0]       dout
);

  logic [WIDTH-1:0] entries [sxt_pkg::QUEUE_DEPTH];
  logic [sxt_pkg::QUEUE_PTR_BITS-1:0]   wr_ptr;
  logic [sxt_pkg::QUEUE_PTR_BITS-1:0]   rd_ptr;
  logic [sxt_pkg::QUEUE_COUNT_BITS-1:0] count;
  logic [sxt_pkg::QUEUE_COUNT_BITS-1:0] count_next;
  logic [sxt_pkg::QUEUE_PTR_BITS-1:0]   wr_ptr_next;
  logic pop;

  // Room for a full two-token request whatever the consumer does.
  assign room      = count <= sxt_pkg::QUEUE_COUNT_BITS'(sxt_pkg::QUEUE_DEPTH - 2);
  assign out_valid = count != '0;
  assign dout      = entries[rd_ptr];
  assign pop       = out_valid && out_ready;

  always_comb begin
    count_next  = count + sxt_pkg::QUEUE_COUNT_BITS'(push.first)
                        + sxt_pkg::QUEUE_COUNT_BITS'(push.second)
                        - sxt_pkg::QUEUE_COUNT_BITS'(pop);
    wr_ptr_next = wr_ptr + sxt_pkg::QUEUE_PTR_BITS'(push.first)
                         + sxt_pkg::QUEUE_PTR_BITS'(push.second);
  end

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr_next;
      count  <= count_next;
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
    end
  end

  // Token storage; the second slot is only written together with the first.
  always_ff @(posedge clk) begin
    if (push.first) begin
      entries[wr_ptr] <= din0;
    end
    if (push.second) begin
      entries[wr_ptr + 1'b1] <= din1;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/sxt_lexer_core.sv
// Lexer core: input byte register, scan state, position counters and the
// per-byte token decision. Depends on sxt_pkg and sxt_if.
`timescale 1ns / 1ps
`default_nettype none

module sxt_lexer_core #(
  parameter int unsigned LINE_BITS   = 16,
  parameter int unsigned COLUMN_BITS = 16,
  parameter int unsigned OFFSET_BITS = 24
) (
  input  wire logic            clk,
  input  wire logic            rst,
  sxt_byte_if.sink             text_in,
  sxt_cfg_if.sink              cfg,
  input  wire logic            room,
  output sxt_pkg::push_t       push,
  output logic [LINE_BITS+COLUMN_BITS+2*OFFSET_BITS+3:0] token0,
  output logic [LINE_BITS+COLUMN_BITS+2*OFFSET_BITS+3:0] token1
);

  // Scan modes.
  localparam logic [2:0] MODE_BETWEEN = 3'd0;
  localparam logic [2:0] MODE_COMMENT = 3'd1;
  localparam logic [2:0] MODE_SIGN    = 3'd2;
  localparam logic [2:0] MODE_INT     = 3'd3;
  localparam logic [2:0] MODE_FRAC    = 3'd4;
  localparam logic [2:0] MODE_SYMBOL  = 3'd5;
  localparam logic [2:0] MODE_ERROR   = 3'd6;

  localparam int unsigned LINE_WIDE = (LINE_BITS > 16) ? LINE_BITS : 16;
  localparam int unsigned COL_WIDE  = (COLUMN_BITS > 16) ? COLUMN_BITS : 16;

  // Configuration registers.
  logic [sxt_pkg::CFG_DATA_BITS-1:0] start_line;
  logic [sxt_pkg::CFG_DATA_BITS-1:0] start_column;

  // Input register.
  logic       full;
  logic [7:0] byte_q;
  logic       last_q;
  logic       fire;

  // Scan state.
  logic [2:0]             mode;
  logic                   fresh;
  logic [LINE_BITS-1:0]   cursor_line;
  logic [COLUMN_BITS-1:0] cursor_column;
  logic [OFFSET_BITS-1:0] cursor_offset;
  logic [LINE_BITS-1:0]   pending_line;
  logic [COLUMN_BITS-1:0] pending_column;
  logic [OFFSET_BITS-1:0] pending_offset;
  logic [OFFSET_BITS-1:0] pending_length;

  logic [2:0]             mode_next;
  logic [LINE_BITS-1:0]   cursor_line_next;
  logic [COLUMN_BITS-1:0] cursor_column_next;
  logic [OFFSET_BITS-1:0] cursor_offset_next;
  logic [LINE_BITS-1:0]   pending_line_next;
  logic [COLUMN_BITS-1:0] pending_column_next;
  logic [OFFSET_BITS-1:0] pending_offset_next;
  logic [OFFSET_BITS-1:0] pending_length_next;

  // Decision signals.
  logic [LINE_WIDE-1:0]   line_ext;
  logic [LINE_WIDE-1:0]   line_max;
  logic [COL_WIDE-1:0]    col_ext;
  logic [COL_WIDE-1:0]    col_max;
  logic [LINE_BITS-1:0]   cur_line;
  logic [COLUMN_BITS-1:0] cur_col;
  logic [OFFSET_BITS-1:0] cur_off;
  logic [2:0]             mode_start;
  logic [2:0]             mode_mid;
  logic                   pend_emit;
  logic [2:0]             pend_kind;
  logic                   len_inc;
  logic                   go_between;
  logic                   imm_emit;
  logic [2:0]             imm_kind;
  logic                   begin_tok;
  logic                   flush_emit;
  logic [2:0]             flush_kind;
  logic [LINE_BITS+COLUMN_BITS+2*OFFSET_BITS+3:0] tok_a;
  logic [LINE_BITS+COLUMN_BITS+2*OFFSET_BITS+3:0] tok_b;
  logic [LINE_BITS+COLUMN_BITS+2*OFFSET_BITS+3:0] tok_c;

  // Register writes are always taken.
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_line   <= sxt_pkg::START_LINE_RESET;
      start_column <= sxt_pkg::START_COLUMN_RESET;
    end else if (cfg.valid) begin
      case (cfg.reg_index)
        sxt_pkg::REG_START_LINE:   start_line   <= cfg.reg_data;
        sxt_pkg::REG_START_COLUMN: start_column <= cfg.reg_data;
        default: ;
      endcase
    end
  end

  // Input register: a byte is processed once the queue has room for two tokens.
  assign fire          = full && room;
  assign text_in.ready = !full || room;

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else if (text_in.valid && text_in.ready) begin
      full <= 1'b1;
    end else if (fire) begin
      full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (text_in.valid && text_in.ready) begin
      byte_q <= text_in.text_byte;
      last_q <= text_in.end_of_text;
    end
  end

  // Cursor for this byte: reloaded from the registers at the start of a text.
  always_comb begin
    line_ext   = LINE_WIDE'(start_line);
    line_max   = LINE_WIDE'({LINE_BITS{1'b1}});
    col_ext    = COL_WIDE'(start_column);
    col_max    = COL_WIDE'({COLUMN_BITS{1'b1}});
    cur_line   = fresh ? LINE_BITS'((line_ext > line_max) ? line_max : line_ext)
                       : cursor_line;
    cur_col    = fresh ? COLUMN_BITS'((col_ext > col_max) ? col_max : col_ext)
                       : cursor_column;
    cur_off    = fresh ? '0 : cursor_offset;
    mode_start = fresh ? MODE_BETWEEN : mode;
  end

  // Pending token: extend it, or close it and rescan the byte as a token start.
  always_comb begin
    pend_emit  = 1'b0;
    pend_kind  = sxt_pkg::KIND_SYMBOL;
    len_inc    = 1'b0;
    go_between = 1'b0;
    mode_mid   = mode_start;
    case (mode_start)
      MODE_SYMBOL: begin
        if (sxt_pkg::is_symbolic(byte_q)) begin
          len_inc = 1'b1;
        end else begin
          pend_emit  = 1'b1;
          go_between = 1'b1;
        end
      end
      MODE_SIGN: begin
        if (sxt_pkg::is_digit(byte_q)) begin
          len_inc  = 1'b1;
          mode_mid = MODE_INT;
        end else if (sxt_pkg::is_symbolic(byte_q)) begin
          len_inc  = 1'b1;
          mode_mid = MODE_SYMBOL;
        end else begin
          pend_emit  = 1'b1;
          go_between = 1'b1;
        end
      end
      MODE_INT: begin
        if (sxt_pkg::is_digit(byte_q)) begin
          len_inc = 1'b1;
        end else if (byte_q == sxt_pkg::CHAR_DOT) begin
          len_inc  = 1'b1;
          mode_mid = MODE_FRAC;
        end else begin
          pend_emit  = 1'b1;
          pend_kind  = sxt_pkg::KIND_INTEGER;
          go_between = 1'b1;
        end
      end
      MODE_FRAC: begin
        if (sxt_pkg::is_digit(byte_q)) begin
          len_inc = 1'b1;
        end else begin
          pend_emit  = 1'b1;
          pend_kind  = sxt_pkg::KIND_DECIMAL;
          go_between = 1'b1;
        end
      end
      MODE_COMMENT: begin
        if (byte_q == sxt_pkg::CHAR_NEWLINE) begin
          mode_mid = MODE_BETWEEN;
        end
      end
      MODE_ERROR: begin
        mode_mid = MODE_ERROR;
      end
      default: begin
        go_between = 1'b1;
      end
    endcase

    // Token start decision.
    imm_emit  = 1'b0;
    imm_kind  = sxt_pkg::KIND_ERROR;
    begin_tok = 1'b0;
    if (go_between) begin
      mode_mid = MODE_BETWEEN;
      if (sxt_pkg::is_space(byte_q)) begin
        mode_mid = MODE_BETWEEN;
      end else if (byte_q == sxt_pkg::CHAR_SEMI) begin
        mode_mid = MODE_COMMENT;
      end else if (byte_q == sxt_pkg::CHAR_LPAREN) begin
        imm_emit = 1'b1;
        imm_kind = sxt_pkg::KIND_LPAREN;
      end else if (byte_q == sxt_pkg::CHAR_RPAREN) begin
        imm_emit = 1'b1;
        imm_kind = sxt_pkg::KIND_RPAREN;
      end else if (byte_q == sxt_pkg::CHAR_QUOTE) begin
        imm_emit = 1'b1;
        imm_kind = sxt_pkg::KIND_QUOTE;
      end else if (sxt_pkg::is_digit(byte_q)) begin
        begin_tok = 1'b1;
        mode_mid  = MODE_INT;
      end else if (sxt_pkg::is_sign(byte_q)) begin
        begin_tok = 1'b1;
        mode_mid  = MODE_SIGN;
      end else if (sxt_pkg::is_symbolic(byte_q)) begin
        begin_tok = 1'b1;
        mode_mid  = MODE_SYMBOL;
      end else begin
        imm_emit = 1'b1;
        mode_mid = MODE_ERROR;
      end
    end
  end

  // Pending token after this byte, and the flush at the end of a text.
  always_comb begin
    if (begin_tok) begin
      pending_line_next   = cur_line;
      pending_column_next = cur_col;
      pending_offset_next = cur_off;
      pending_length_next = OFFSET_BITS'(1);
    end else begin
      pending_line_next   = pending_line;
      pending_column_next = pending_column;
      pending_offset_next = pending_offset;
      pending_length_next = (len_inc && !(&pending_length)) ? pending_length + 1'b1
                                                            : pending_length;
    end

    flush_emit = 1'b0;
    flush_kind = sxt_pkg::KIND_SYMBOL;
    if (last_q) begin
      case (mode_mid)
        MODE_SIGN, MODE_SYMBOL: flush_emit = 1'b1;
        MODE_INT: begin
          flush_emit = 1'b1;
          flush_kind = sxt_pkg::KIND_INTEGER;
        end
        MODE_FRAC: begin
          flush_emit = 1'b1;
          flush_kind = sxt_pkg::KIND_DECIMAL;
        end
        default: ;
      endcase
    end
    mode_next = last_q ? MODE_BETWEEN : mode_mid;
  end

  // Cursor advance: a newline starts a new line at column zero.
  always_comb begin
    if (byte_q == sxt_pkg::CHAR_NEWLINE) begin
      cursor_column_next = '0;
      cursor_line_next   = (&cur_line) ? cur_line : cur_line + 1'b1;
    end else begin
      cursor_column_next = (&cur_col) ? cur_col : cur_col + 1'b1;
      cursor_line_next   = cur_line;
    end
    cursor_offset_next = (&cur_off) ? cur_off : cur_off + 1'b1;
  end

  // Token candidates in emission order, then packed into the two slots.
  always_comb begin
    tok_a = {pend_kind, pending_line, pending_column, pending_offset, pending_length, 1'b0};
    tok_b = {imm_kind, cur_line, cur_col, cur_off,
             (imm_kind == sxt_pkg::KIND_ERROR) ? OFFSET_BITS'(0) : OFFSET_BITS'(1), 1'b0};
    tok_c = {flush_kind, pending_line_next, pending_column_next, pending_offset_next,
             pending_length_next, 1'b0};

    if (pend_emit) begin
      token0 = tok_a;
    end else if (imm_emit) begin
      token0 = tok_b;
    end else begin
      token0 = tok_c;
    end
    token1 = imm_emit ? tok_b : tok_c;

    push.first  = fire && (pend_emit || imm_emit || flush_emit);
    push.second = fire && pend_emit && (imm_emit || flush_emit);
    token0[0]   = !(pend_emit && (imm_emit || flush_emit));
    token1[0]   = 1'b1;
  end

  // Scan state update, one byte per cycle while a byte is held and the queue has room.
  always_ff @(posedge clk) begin
    if (rst) begin
      mode           <= MODE_BETWEEN;
      fresh          <= 1'b1;
      cursor_line    <= '0;
      cursor_column  <= '0;
      cursor_offset  <= '0;
      pending_line   <= '0;
      pending_column <= '0;
      pending_offset <= '0;
      pending_length <= '0;
    end else if (fire) begin
      mode           <= mode_next;
      fresh          <= last_q;
      cursor_line    <= cursor_line_next;
      cursor_column  <= cursor_column_next;
      cursor_offset  <= cursor_offset_next;
      pending_line   <= pending_line_next;
      pending_column <= pending_column_next;
      pending_offset <= pending_offset_next;
      pending_length <= pending_length_next;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/sexpr_tokenizer.sv
// Top level of the S-expression tokenizer: lexer core and token queue.
// Depends on sxt_pkg, sxt_if, sxt_lexer_core and sxt_token_fifo.
`timescale 1ns / 1ps
`default_nettype none

// The tokenizer takes one byte of source text per cycle on text_in, while its
// token queue has room, and gives parenthesis, quote, integer, decimal, symbol
// and error tokens on tokens, each with its kind, the line and column of its
// first byte, its byte offset in the text and its length. A byte is taken into
// an input register, decided from that register once the queue has room, and
// its tokens are written into a four-entry queue whose head is shown on tokens.
// A byte yields at most two tokens; the queue takes both at once, and a byte is
// decided only when the queue has room for two, so the block sustains one byte
// per cycle as long as the consumer takes one token per cycle and bytes with
// two tokens do not fill the queue. The start line and column registers are
// loaded into the cursor on the first byte of each text; write them only while
// no byte is in flight.
module sexpr_tokenizer #(
  parameter int unsigned LINE_BITS   = 16,
  parameter int unsigned COLUMN_BITS = 16,
  parameter int unsigned OFFSET_BITS = 24
) (
  input wire logic    clk,
  input wire logic    rst,
  sxt_byte_if.sink    text_in,
  sxt_cfg_if.sink     cfg,
  sxt_token_if.source tokens
);

  localparam int unsigned TOKEN_BITS = LINE_BITS + COLUMN_BITS + 2 * OFFSET_BITS + 4;

  sxt_pkg::push_t        push;
  logic                  room;
  logic [TOKEN_BITS-1:0] token0;
  logic [TOKEN_BITS-1:0] token1;
  logic [TOKEN_BITS-1:0] head;

  // Per-byte decision and position tracking.
  sxt_lexer_core #(
    .LINE_BITS   (LINE_BITS),
    .COLUMN_BITS (COLUMN_BITS),
    .OFFSET_BITS (OFFSET_BITS)
  ) u_core (
    .clk     (clk),
    .rst     (rst),
    .text_in (text_in),
    .cfg     (cfg),
    .room    (room),
    .push    (push),
    .token0  (token0),
    .token1  (token1)
  );

  // Output queue between the decision and the consumer.
  sxt_token_fifo #(
    .WIDTH (TOKEN_BITS)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .din0      (token0),
    .din1      (token1),
    .room      (room),
    .out_valid (tokens.valid),
    .out_ready (tokens.ready),
    .dout      (head)
  );

  // Unpack the head token onto the channel.
  assign {tokens.token_kind, tokens.token_line, tokens.token_column, tokens.token_offset,
          tokens.token_length, tokens.run_last} = head;

endmodule

`default_nettype wire
